@@ design/bounded_key_value_table_assert.svh @@
// ============================================================================
// Assertion macros for the key/value table
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ============================================================================
`ifndef BOUNDED_KEY_VALUE_TABLE_ASSERT_SVH
`define BOUNDED_KEY_VALUE_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold whenever the antecedent holds.
`define KVT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// The consequent must hold in the cycle after the antecedent.
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante then cons");

// The condition must never be true.
`define KVT_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition");

`else

`define KVT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define KVT_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ design/kvt_pkg.sv @@
// ============================================================================
// Key/value table package
// Field widths, operation codes and the controller/datapath command bundles.
// ============================================================================
`default_nettype none

package kvt_pkg;

    // Fixed widths of the request and response words.
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 4;
    localparam int OP_W      = 3;
    localparam int COUNT_W   = 5;
    localparam int CAP_W     = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes; code 7 is unused and does nothing.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 3'd0,
        OP_UPDATE     = 3'd1,
        OP_INS_OR_UPD = 3'd2,
        OP_ERASE      = 3'd3,
        OP_CONTAINS   = 3'd4,
        OP_GET_KEY    = 3'd5,
        OP_GET_POS    = 3'd6
    } op_t;

    // Read address select.
    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_NEXT = 2'd1,
        RD_POS  = 2'd2
    } rd_sel_t;

    // Write address and data select.
    typedef enum logic [1:0] {
        WR_APPEND = 2'd0,
        WR_UPDATE = 2'd1,
        WR_SHIFT  = 2'd2
    } wr_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    start;
        logic    idx_inc;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    mark_found;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_ok;
        logic    set_kout;
        logic    set_vout;
        logic    out_load;
    } kvt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic found;
        logic idx_at_end;
        logic key_match;
        logic next_in_use;
        logic can_append;
        logic pos_in_use;
    } kvt_sts_t;

endpackage

`default_nettype wire

@@ design/kvt_req_if.sv @@
// ============================================================================
// Request channel
// Valid/ready channel that carries one operation word.
// ============================================================================
`default_nettype none

interface kvt_req_if;

    logic                        valid;
    logic                        ready;
    logic [kvt_pkg::OP_W-1:0]    op;
    logic [kvt_pkg::KEY_W-1:0]   key;
    logic [kvt_pkg::VAL_W-1:0]   value;
    logic [kvt_pkg::POS_W-1:0]   position;

    modport source (output valid, output op, output key, output value, output position,
                    input ready);
    modport sink   (input valid, input op, input key, input value, input position,
                    output ready);

endinterface

`default_nettype wire

@@ design/kvt_rsp_if.sv @@
// ============================================================================
// Response channel
// Valid/ready channel that carries one result word.
// ============================================================================
`default_nettype none

interface kvt_rsp_if;

    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [kvt_pkg::KEY_W-1:0]     key_out;
    logic [kvt_pkg::VAL_W-1:0]     value_out;
    logic [kvt_pkg::COUNT_W-1:0]   count;
    logic                          is_empty;

    modport source (output valid, output ok, output key_out, output value_out,
                    output count, output is_empty, input ready);
    modport sink   (input valid, input ok, input key_out, input value_out,
                    input count, input is_empty, output ready);

endinterface

`default_nettype wire

@@ design/kvt_ctrl.sv @@
// ============================================================================
// Key/value table controller
// Sequences search, append, update, erase shift, position read and result delivery.
// ============================================================================
`default_nettype none

module kvt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire kvt_pkg::op_t      in_op,
    output logic                   in_ready,
    input  wire logic              out_ready,
    output logic                   out_valid,
    input  wire kvt_pkg::kvt_sts_t sts,
    output kvt_pkg::kvt_cmd_t      cmd
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SRD  = 9'b000000010,
        ST_SCMP = 9'b000000100,
        ST_EXEC = 9'b000001000,
        ST_PRD  = 9'b000010000,
        ST_PCMP = 9'b000100000,
        ST_ERD  = 9'b001000000,
        ST_EWR  = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    unique case (in_op)
                        kvt_pkg::OP_GET_POS:    state_next = ST_PRD;
                        kvt_pkg::OP_INSERT,
                        kvt_pkg::OP_UPDATE,
                        kvt_pkg::OP_INS_OR_UPD,
                        kvt_pkg::OP_ERASE,
                        kvt_pkg::OP_CONTAINS,
                        kvt_pkg::OP_GET_KEY:    state_next = ST_SRD;
                        default:                state_next = ST_DONE;
                    endcase
                end
            end
            ST_SRD:
            begin
                if (sts.idx_at_end)
                begin
                    state_next = ST_EXEC;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = kvt_pkg::RD_IDX;
                    state_next = ST_SCMP;
                end
            end
            ST_SCMP:
            begin
                if (sts.key_match)
                begin
                    cmd.mark_found = 1'b1;
                    cmd.set_vout   = (sts.op == kvt_pkg::OP_GET_KEY);
                    state_next     = ST_EXEC;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SRD;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                unique case (sts.op)
                    kvt_pkg::OP_INSERT:
                    begin
                        if (!sts.found && sts.can_append)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = kvt_pkg::WR_APPEND;
                            cmd.cnt_inc = 1'b1;
                            cmd.set_ok  = 1'b1;
                        end
                    end
                    kvt_pkg::OP_UPDATE:
                    begin
                        if (sts.found)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = kvt_pkg::WR_UPDATE;
                            cmd.set_ok = 1'b1;
                        end
                    end
                    kvt_pkg::OP_INS_OR_UPD:
                    begin
                        if (sts.found)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = kvt_pkg::WR_UPDATE;
                            cmd.set_ok = 1'b1;
                        end
                        else if (sts.can_append)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = kvt_pkg::WR_APPEND;
                            cmd.cnt_inc = 1'b1;
                            cmd.set_ok  = 1'b1;
                        end
                    end
                    kvt_pkg::OP_ERASE:
                    begin
                        if (sts.found)
                        begin
                            state_next = ST_ERD;
                        end
                    end
                    kvt_pkg::OP_CONTAINS,
                    kvt_pkg::OP_GET_KEY:
                    begin
                        cmd.set_ok = sts.found;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_PRD:
            begin
                if (sts.pos_in_use)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = kvt_pkg::RD_POS;
                    state_next = ST_PCMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PCMP:
            begin
                cmd.set_ok   = 1'b1;
                cmd.set_kout = 1'b1;
                cmd.set_vout = 1'b1;
                state_next   = ST_DONE;
            end
            ST_ERD:
            begin
                // Move the next entry down, or close the list when none is left.
                if (sts.next_in_use)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = kvt_pkg::RD_NEXT;
                    state_next = ST_EWR;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.set_ok  = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_EWR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = kvt_pkg::WR_SHIFT;
                cmd.idx_inc = 1'b1;
                state_next  = ST_ERD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output word stays valid until it is taken.
    assign out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ design/kvt_dpath.sv @@
// ============================================================================
// Key/value table datapath
// Entry memory, count, capacity, search index and the output register.
// ============================================================================
`default_nettype none

module kvt_dpath #(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [kvt_pkg::CAP_W-1:0]       cfg_data,
    input  wire logic [kvt_pkg::OP_W-1:0]        req_op,
    input  wire logic [kvt_pkg::KEY_W-1:0]       req_key,
    input  wire logic [kvt_pkg::VAL_W-1:0]       req_value,
    input  wire logic [kvt_pkg::POS_W-1:0]       req_pos,
    input  wire kvt_pkg::kvt_cmd_t               cmd,
    output kvt_pkg::kvt_sts_t                    sts,
    output logic                                 out_ok,
    output logic [kvt_pkg::KEY_W-1:0]            out_key,
    output logic [kvt_pkg::VAL_W-1:0]            out_value,
    output logic [kvt_pkg::COUNT_W-1:0]          out_count,
    output logic                                 out_empty
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > kvt_pkg::POS_W) ? CNT_W : kvt_pkg::POS_W;
    localparam int ROW_W = KEY_WIDTH + VALUE_WIDTH;

    // Entry store: one row holds a key and its value.
    logic [ROW_W-1:0]       mem [DEPTH];
    logic [ROW_W-1:0]       rdata_reg;

    logic [kvt_pkg::CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   found_reg, found_next;

    kvt_pkg::op_t           op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [kvt_pkg::POS_W-1:0] pos_reg;

    logic                   res_ok_reg;
    logic [kvt_pkg::KEY_W-1:0] res_key_reg;
    logic [kvt_pkg::VAL_W-1:0] res_val_reg;

    logic                   out_ok_reg;
    logic [kvt_pkg::KEY_W-1:0] out_key_reg;
    logic [kvt_pkg::VAL_W-1:0] out_val_reg;
    logic [kvt_pkg::COUNT_W-1:0] out_count_reg;
    logic                   out_empty_reg;

    logic [63:0]            key_in64, val_in64, rd_key64, rd_val64;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic [CNT_W-1:0]       idx_plus;
    logic [CMP_W-1:0]       pos_ext, count_ext;
    logic [31:0]            count32;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic [ROW_W-1:0]       wr_row;

    // Width conversion between the fixed fields and the stored entries.
    assign key_in64 = 64'(req_key);
    assign val_in64 = 64'(req_value);
    assign rd_key   = rdata_reg[ROW_W-1:VALUE_WIDTH];
    assign rd_val   = rdata_reg[VALUE_WIDTH-1:0];
    assign rd_key64 = 64'(rd_key);
    assign rd_val64 = 64'(rd_val);

    assign idx_plus  = idx_reg + 1'b1;
    assign pos_ext   = CMP_W'(pos_reg);
    assign count_ext = CMP_W'(count_reg);
    assign count32   = 32'(count_reg);

    // Status back to the controller.
    assign sts.op          = op_reg;
    assign sts.found       = found_reg;
    assign sts.idx_at_end  = (idx_reg == count_reg);
    assign sts.key_match   = (rd_key == key_reg);
    assign sts.next_in_use = (idx_plus < count_reg);
    assign sts.can_append  = (count32 < 32'(cap_reg)) && (count32 < 32'(DEPTH));
    assign sts.pos_in_use  = (pos_ext < count_ext);

    // Memory addresses and write data.
    always_comb
    begin
        unique case (cmd.rd_sel)
            kvt_pkg::RD_IDX:  rd_addr = idx_reg[AW-1:0];
            kvt_pkg::RD_NEXT: rd_addr = idx_plus[AW-1:0];
            kvt_pkg::RD_POS:  rd_addr = pos_ext[AW-1:0];
            default:          rd_addr = idx_reg[AW-1:0];
        endcase
        unique case (cmd.wr_sel)
            kvt_pkg::WR_APPEND:
            begin
                wr_addr = count_reg[AW-1:0];
                wr_row  = {key_reg, val_reg};
            end
            kvt_pkg::WR_UPDATE:
            begin
                wr_addr = idx_reg[AW-1:0];
                wr_row  = {key_reg, val_reg};
            end
            kvt_pkg::WR_SHIFT:
            begin
                wr_addr = idx_reg[AW-1:0];
                wr_row  = rdata_reg;
            end
            default:
            begin
                wr_addr = idx_reg[AW-1:0];
                wr_row  = rdata_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Count, search index and found flag.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - 1'b1;
        end

        idx_next   = idx_reg;
        found_next = found_reg;
        if (cmd.start)
        begin
            idx_next   = '0;
            found_next = 1'b0;
        end
        else
        begin
            if (cmd.idx_inc)
            begin
                idx_next = idx_plus;
            end
            if (cmd.mark_found)
            begin
                found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= kvt_pkg::CAP_RESET;
            count_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            count_reg <= count_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    // Request capture and result assembly.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg      <= kvt_pkg::op_t'(req_op);
            key_reg     <= key_in64[KEY_WIDTH-1:0];
            val_reg     <= val_in64[VALUE_WIDTH-1:0];
            pos_reg     <= req_pos;
            res_ok_reg  <= 1'b0;
            res_key_reg <= '0;
            res_val_reg <= '0;
        end
        else
        begin
            if (cmd.set_ok)
            begin
                res_ok_reg <= 1'b1;
            end
            if (cmd.set_kout)
            begin
                res_key_reg <= rd_key64[kvt_pkg::KEY_W-1:0];
            end
            if (cmd.set_vout)
            begin
                res_val_reg <= rd_val64[kvt_pkg::VAL_W-1:0];
            end
        end
    end

    // Output register, loaded once the operation is complete.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_ok_reg    <= res_ok_reg;
            out_key_reg   <= res_key_reg;
            out_val_reg   <= res_val_reg;
            out_count_reg <= count32[kvt_pkg::COUNT_W-1:0];
            out_empty_reg <= (count_reg == '0);
        end
    end

    assign out_ok    = out_ok_reg;
    assign out_key   = out_key_reg;
    assign out_value = out_val_reg;
    assign out_count = out_count_reg;
    assign out_empty = out_empty_reg;

endmodule

`default_nettype wire

@@ design/bounded_key_value_table.sv @@
// ============================================================================
// Bounded key/value table
// Fixed-capacity map kept as a packed list in insertion order.
// ============================================================================
//
//  Channel   Direction   Handshake          Carries
//  -------   ---------   ----------------   ---------------------------------
//  req       in          valid/ready        op, key, value, position
//  rsp       out         valid/ready        ok, key_out, value_out, count,
//                                           is_empty
//  cfg       in          cfg_we only        capacity (cfg_data)
//
// One request word is worked on at a time. The key search reads one entry
// from the entry memory and compares its key before it reads the next, and
// erase moves each later entry down by reading it and writing it one place
// lower. A position read reads the entry at that position, if it is in use,
// and then sets the result. The done state stalls while the previous word
// is still waiting in the output register; otherwise a finished word waits
// there while the next request is accepted. Reset clears the count and sets
// the capacity to sixteen; the entry memory itself is not cleared.
//
`default_nettype none

`include "bounded_key_value_table_assert.svh"

module bounded_key_value_table #(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    kvt_req_if.sink                            req,
    kvt_rsp_if.source                          rsp,
    input  wire logic                          cfg_we,
    input  wire logic [kvt_pkg::CAP_W-1:0]     cfg_data
);

    kvt_pkg::kvt_cmd_t cmd;
    kvt_pkg::kvt_sts_t sts;

    // Controller: sequencing and handshakes.
    kvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_op     (kvt_pkg::op_t'(req.op)),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: entry storage and result words.
    kvt_dpath #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_op    (req.op),
        .req_key   (req.key),
        .req_value (req.value),
        .req_pos   (req.position),
        .cmd       (cmd),
        .sts       (sts),
        .out_ok    (rsp.ok),
        .out_key   (rsp.key_out),
        .out_value (rsp.value_out),
        .out_count (rsp.count),
        .out_empty (rsp.is_empty)
    );

    // An accepted word never coincides with an entry write.
    `KVT_ASSERT_NEVER(a_no_write_on_accept, clk, rst_n, cmd.wr_en && req.valid && req.ready)
    // A finished word is loaded only when the output register is free or being emptied.
    `KVT_ASSERT_IMPLY(a_load_when_free, clk, rst_n, cmd.out_load, !rsp.valid || rsp.ready)
    // The count grows only when there is room.
    `KVT_ASSERT_IMPLY(a_append_has_room, clk, rst_n, cmd.cnt_inc, sts.can_append && !cmd.cnt_dec)

endmodule

`default_nettype wire
